// File: rtl/core/utf16_to_utf8_text_filter_assert.svh
// Assertion macros for the UTF-16 to UTF-8 text filter.
// Included by the top level; compiles to nothing when SYNTH is defined.
`ifndef UTF16_TO_UTF8_TEXT_FILTER_ASSERT_SVH
`define UTF16_TO_UTF8_TEXT_FILTER_ASSERT_SVH

`ifndef SYNTH
// clocked assertion, muted while reset is high
`define U8TF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("u8tf assertion failed");
// clocked assertion that also holds during reset
`define U8TF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("u8tf assertion failed");
`else
`define U8TF_ASSERT(label, clk, rst, prop)
`define U8TF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: rtl/core/u8tf_pkg.sv
// Shared types and constants of the UTF-16 to UTF-8 text filter.
// Used by the front end, the job queue, the back end and the top level.
package u8tf_pkg;

   // code point ranges
   localparam logic [20:0] HI_FIRST    = 21'h00D800;
   localparam logic [20:0] HI_LAST     = 21'h00DBFF;
   localparam logic [20:0] LO_FIRST    = 21'h00DC00;
   localparam logic [20:0] LO_LAST     = 21'h00DFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;
   localparam logic [20:0] PUA_FIRST   = 21'h00E000;
   localparam logic [20:0] PUA_LAST    = 21'h00F8FF;
   localparam logic [20:0] SPEC_FIRST  = 21'h00FFF0;
   localparam logic [20:0] SPEC_LAST   = 21'h00FFFF;
   localparam logic [20:0] SPACE_CP    = 21'h000020;
   localparam logic [20:0] C1_FIRST    = 21'h00007F;
   localparam logic [20:0] C1_LAST     = 21'h00009F;
   localparam logic [20:0] TWO_BYTE_CP = 21'h000080;
   localparam logic [20:0] THREE_BYTE_CP = 21'h000800;

   // UTF-8 byte of the space character
   localparam logic [7:0] SPACE_BYTE = 8'h20;

   // a job carries up to five bytes: an owed space plus a four-byte sequence
   localparam int JOB_BYTES = 5;
   localparam logic [2:0] JOB_MAX = 3'd5;

   // default queue depth between front and back end
   localparam int U8TF_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;     // bytes in output order, entry 0 first
      logic [2:0]                count;    // number of results, 1..5
      logic                      present;  // 0 for a bare end mark
      logic                      last;     // job ends the string
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_push_type;

endpackage

// File: rtl/core/u8tf_queue.sv
// Small job queue between the front end and the back end.
// Depends on u8tf_pkg for the job type.
module u8tf_queue import u8tf_pkg::*; #(
   parameter int DEPTH = U8TF_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push,
   output logic           push_ready,
   output logic           pop_valid,
   output job_type        pop_job,
   input  logic           pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// File: rtl/core/u8tf_front.sv
// Front end: accepts code units, pairs surrogates, filters spaces and
// encodes each code point into a job of UTF-8 bytes. Depends on u8tf_pkg.
module u8tf_front import u8tf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [15:0]    code_unit,
   input  logic           end_of_string,
   output queue_push_type push,
   input  logic           push_ready
);

   logic        high_held_ff, high_held_in;
   logic [9:0]  high_bits_ff, high_bits_in;
   logic        space_owed_ff, space_owed_in;
   logic        emitted_ff, emitted_in;

   logic        accept;
   logic        is_high, is_low, join_pair, emit_pt, is_space;
   logic [20:0] unit_cp, cp;
   logic [3:0][7:0] enc;
   logic [2:0]  enc_n;
   logic        put_space;
   job_type     job;

   // a unit is taken whenever the queue has room
   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   // classify the unit
   assign unit_cp   = {5'd0, code_unit};
   assign is_high   = (unit_cp >= HI_FIRST) && (unit_cp <= HI_LAST);
   assign is_low    = (unit_cp >= LO_FIRST) && (unit_cp <= LO_LAST);
   assign join_pair = high_held_ff && is_low;
   assign emit_pt   = join_pair || (is_high ? end_of_string : !is_low);
   assign cp        = join_pair ? (SUPP_BASE + {1'b0, high_bits_ff, code_unit[9:0]}) : unit_cp;

   assign is_space = (cp <= SPACE_CP)
                  || ((cp >= C1_FIRST) && (cp <= C1_LAST))
                  || ((cp >= PUA_FIRST) && (cp <= PUA_LAST))
                  || ((cp >= SPEC_FIRST) && (cp <= SPEC_LAST));

   // UTF-8 encoding of a non-space code point
   always_comb begin
      enc = '0;
      if (cp < TWO_BYTE_CP) begin
         enc[0] = cp[7:0];
         enc_n  = 3'd1;
      end else if (cp < THREE_BYTE_CP) begin
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
         enc_n  = 3'd2;
      end else if (cp < SUPP_BASE) begin
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
         enc_n  = 3'd3;
      end else begin
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
         enc[3] = {2'b10, cp[5:0]};
         enc_n  = 3'd4;
      end
   end

   assign put_space = emit_pt && !is_space && space_owed_ff;

   // build the job, an owed space goes first
   always_comb begin
      job         = '0;
      job.present = 1'b1;
      job.last    = end_of_string;
      if (emit_pt && !is_space) begin
         if (put_space) begin
            job.data[0]   = SPACE_BYTE;
            job.data[4:1] = enc;
            job.count     = enc_n + 3'd1;
         end else begin
            job.data[3:0] = enc;
            job.count     = enc_n;
         end
      end
      // final unit with no byte: bare end mark
      if (end_of_string && (job.count == 3'd0)) begin
         job.count   = 3'd1;
         job.present = 1'b0;
      end
   end

   assign push.valid = accept && (job.count != 3'd0);
   assign push.job   = job;

   // string state update
   always_comb begin
      high_held_in  = high_held_ff;
      high_bits_in  = high_bits_ff;
      space_owed_in = space_owed_ff;
      emitted_in    = emitted_ff;
      if (accept) begin
         if (end_of_string) begin
            high_held_in  = 1'b0;
            high_bits_in  = '0;
            space_owed_in = 1'b0;
            emitted_in    = 1'b0;
         end else begin
            high_held_in = is_high;
            if (is_high) begin
               high_bits_in = code_unit[9:0];
            end
            if (emit_pt && is_space) begin
               space_owed_in = space_owed_ff || emitted_ff;
            end else if (emit_pt) begin
               space_owed_in = 1'b0;
               emitted_in    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_held_ff  <= 1'b0;
         high_bits_ff  <= '0;
         space_owed_ff <= 1'b0;
         emitted_ff    <= 1'b0;
      end else begin
         high_held_ff  <= high_held_in;
         high_bits_ff  <= high_bits_in;
         space_owed_ff <= space_owed_in;
         emitted_ff    <= emitted_in;
      end
   end

endmodule

// File: rtl/core/u8tf_back.sv
// Back end: takes jobs from the queue and sends their bytes one per cycle
// while out_ready is high, via a registered output. Depends on u8tf_pkg.
module u8tf_back import u8tf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       byte_present,
   output logic       string_done
);

   logic       busy_ff, busy_in;
   job_type    job_ff, job_in;
   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       present_ff, present_in;
   logic       done_ff, done_in;
   logic       load, final_byte, take;

   // output register loads from the held job whenever it is empty or being drained
   assign load       = busy_ff && (!valid_ff || out_ready);
   assign final_byte = (idx_ff == (job_ff.count - 3'd1));
   assign take       = !busy_ff || (load && final_byte);
   assign job_pop    = take && job_valid;

   // job register and byte index
   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      idx_in  = idx_ff;
      if (take) begin
         busy_in = job_valid;
         job_in  = job;
         idx_in  = '0;
      end else if (load) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   // output stage
   always_comb begin
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      present_in = present_ff;
      done_in    = done_ff;
      if (load) begin
         valid_in   = 1'b1;
         byte_in    = job_ff.data[idx_ff];
         present_in = job_ff.present;
         done_in    = job_ff.last && final_byte;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      byte_ff    <= byte_in;
      present_ff <= present_in;
      done_ff    <= done_in;
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign byte_present = present_ff;
   assign string_done  = done_ff;

endmodule

// File: rtl/core/utf16_to_utf8_text_filter.sv
// UTF-16 to UTF-8 text filter, top level.
// Input stream (req_): one UTF-16 code unit per transaction in req_tdata,
// req_tlast high on the final unit of a string.
// Output stream (rsp_): one UTF-8 byte per transaction in rsp_tdata;
// rsp_tuser is high when the byte carries data and low for a bare end
// mark; rsp_tlast marks the final transaction of a string.
// Surrogate pairs are joined; lone surrogates are dropped, except a high
// one on the final unit, which is encoded. Control, private-use and
// U+FFF0..U+FFFF code points read as spaces; space runs are collapsed
// and trimmed. A string always ends with exactly one rsp_tlast
// transaction. A unit's bytes pass through the job queue, the back end's
// job register and its output register; a unit yields 0 to 5 bytes. The
// back end sends one byte per cycle while rsp_tready is high. The front
// end takes a unit every cycle while the job queue (QUEUE_DEPTH entries)
// has room. Reset (synchronous, active high) empties the queue and output
// register and starts a new string. When rsp_tready is low the output
// holds, the queue fills, and req_tready drops once it is full.
`include "utf16_to_utf8_text_filter_assert.svh"

module utf16_to_utf8_text_filter import u8tf_pkg::*; #(
   parameter int QUEUE_DEPTH = U8TF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] byte_present
   output logic        rsp_tlast    // string_done
);

   queue_push_type push;
   logic           push_ready;
   logic           q_valid;
   job_type        q_job;
   logic           q_pop;

   u8tf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .code_unit     (req_tdata),
      .end_of_string (req_tlast),
      .push          (push),
      .push_ready    (push_ready)
   );

   u8tf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_job    (q_job),
      .pop        (q_pop)
   );

   u8tf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (q_valid),
      .job          (q_job),
      .job_pop      (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .byte_present (rsp_tuser),
      .string_done  (rsp_tlast)
   );

   // every final unit leaves a job behind
   `U8TF_ASSERT(a_last_pushes, clock, reset, (req_tvalid && req_tready && req_tlast) |-> push.valid)
   // queued jobs carry one to five results
   `U8TF_ASSERT(a_job_count, clock, reset, q_valid |-> (q_job.count != 3'd0 && q_job.count <= JOB_MAX))
   // a bare end mark is always the end of the string
   `U8TF_ASSERT(a_bare_is_last, clock, reset, (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
   // nothing leaves the output stage during or right after reset
   `U8TF_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid)

endmodule
